[rtl/key_table_insert_search_delete_core_defines.svh]
// ----------------------------------------------------------------------------
// Key table core: assertion macros
// Shared concurrent assertion shorthands, clocked on aclk and disabled while
// aresetn is low.
// ----------------------------------------------------------------------------
`ifndef KEY_TABLE_INSERT_SEARCH_DELETE_CORE_DEFINES_SVH
`define KEY_TABLE_INSERT_SEARCH_DELETE_CORE_DEFINES_SVH

// Same-cycle implication.
`define KT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kt_pkg.sv]
// ----------------------------------------------------------------------------
// Key table package
// Field widths, operation and status codes, and the result record that the
// sequencer hands to the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kt_pkg;

    localparam int KT_CAPACITY = 16;
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int FILL_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_SEARCH  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_DELETE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [FILL_W-1:0]   fill;
    } kt_result_t;

endpackage

`default_nettype wire

[rtl/kt_store.sv]
// ----------------------------------------------------------------------------
// Key table storage
// Single write port, single read port key memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kt_store #(
    parameter int DEPTH = kt_pkg::KT_CAPACITY,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            wr_en,
    input  wire logic [IDX_W-1:0]                wr_addr,
    input  wire logic signed [kt_pkg::KEY_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]                rd_addr,
    output logic signed [kt_pkg::KEY_W-1:0]      rd_data
);
    import kt_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/kt_seq.sv]
// ----------------------------------------------------------------------------
// Key table sequencer
// Holds the fill count and walks the table one entry at a time through a
// single shared key comparator, then shifts entries down for a delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kt_seq #(
    parameter int CAPACITY = kt_pkg::KT_CAPACITY,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Request side
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [kt_pkg::OP_W-1:0]         in_op,
    input  wire logic signed [kt_pkg::KEY_W-1:0] in_key,
    input  wire logic signed [kt_pkg::KEY_W-1:0] in_new_key,
    // Result side
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output kt_pkg::kt_result_t                   res,
    // Memory port
    output logic                                 mem_we,
    output logic [IDX_W-1:0]                     mem_waddr,
    output logic signed [kt_pkg::KEY_W-1:0]      mem_wdata,
    output logic [IDX_W-1:0]                     mem_raddr,
    input  wire logic signed [kt_pkg::KEY_W-1:0] mem_rdata
);
    import kt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] new_key_reg, new_key_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    status_t                 status_reg, status_next;

    logic                    hit;
    logic                    last;
    logic                    shift_last;

    // Shared comparator and end-of-table checks.
    assign hit        = (mem_rdata == key_reg);
    assign last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign shift_last = ((CNT_W'(idx_reg) + CNT_W'(2)) == count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.slot   = SLOT_W'(pos_reg);
    assign res.fill   = FILL_W'(count_reg);

    // Next-state logic.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        new_key_next = new_key_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = key_reg;
        mem_raddr    = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next      = op_t'(in_op);
                    key_next     = in_key;
                    new_key_next = in_new_key;
                    idx_next     = '0;
                    pos_next     = '0;
                    status_next  = ST_OK;
                    state_next   = S_READ;
                    case (op_t'(in_op))
                        OP_INSERT: begin
                            if (count_reg >= CNT_W'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else if (count_reg == '0) begin
                                // Empty table: append straight away.
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_key;
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_DONE;
                            end
                        end
                        OP_SEARCH: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_READ: begin
                mem_raddr  = idx_reg;
                state_next = S_CMP;
            end

            S_CMP: begin
                if (hit) begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_INSERT: begin
                            status_next = ST_DUP;
                        end
                        OP_SEARCH: begin
                            pos_next = idx_reg;
                        end
                        OP_REPLACE: begin
                            pos_next  = idx_reg;
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg;
                            mem_wdata = new_key_reg;
                        end
                        default: begin
                            pos_next = idx_reg;
                            if (last) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                state_next = S_SHRD;
                            end
                        end
                    endcase
                end else if (last) begin
                    state_next = S_DONE;
                    if (op_reg == OP_INSERT) begin
                        // No duplicate: append at the fill count.
                        mem_we     = 1'b1;
                        mem_waddr  = IDX_W'(count_reg);
                        mem_wdata  = key_reg;
                        pos_next   = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        status_next = ST_NOTFOUND;
                    end
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end

            S_SHRD: begin
                mem_raddr  = idx_reg + IDX_W'(1);
                state_next = S_SHWR;
            end

            S_SHWR: begin
                // Move the entry above down into the current slot.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = idx_reg + IDX_W'(1);
                if (shift_last) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    state_next = S_SHRD;
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        new_key_reg <= new_key_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
    end

endmodule

`default_nettype wire

[rtl/key_table_insert_search_delete_core.sv]
// Key table core.
// Keeps a packed table of up to CAPACITY signed 32-bit keys and a fill count.
// Requests arrive on the s_ channel (s_op, s_key, s_new_key) with s_valid and
// s_ready; one result per request leaves on the m_ channel (m_status, m_slot,
// m_fill) with m_valid and m_ready.
// One item is worked on at a time and s_ready is low while it runs. The table
// is walked by one comparator, one entry at a time (memory read, then
// compare); a delete then shifts each entry above the match down one slot
// (read, then write). An insert into a full or empty table, or any other
// request on an empty table, finishes without walking the table.
// The result sits in an output register, so the next item is accepted while
// an earlier result still waits; if the receiver stalls, the sequencer holds
// its finished result until the output register frees up.
// Reset (synchronous, active low) empties the table and drops any pending
// result; the key memory itself is not cleared, as only entries below the
// fill count are ever read.
// ----------------------------------------------------------------------------
// Key table core: top level
// Sequencer, key memory and output register of the insert/search/delete table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_table_insert_search_delete_core_defines.svh"

module key_table_insert_search_delete_core #(
    parameter int CAPACITY = kt_pkg::KT_CAPACITY
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [kt_pkg::OP_W-1:0]         s_op,
    input  wire logic signed [kt_pkg::KEY_W-1:0] s_key,
    input  wire logic signed [kt_pkg::KEY_W-1:0] s_new_key,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [kt_pkg::STATUS_W-1:0]          m_status,
    output logic [kt_pkg::SLOT_W-1:0]            m_slot,
    output logic [kt_pkg::FILL_W-1:0]            m_fill
);
    import kt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                    res_valid;
    logic                    res_ready;
    kt_result_t              res;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic signed [KEY_W-1:0] mem_rdata;

    logic                    m_valid_reg, m_valid_next;
    kt_result_t              m_res_reg;

    // Sequencer with the shared comparator.
    kt_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_op      (s_op),
        .in_key     (s_key),
        .in_new_key (s_new_key),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Key memory.
    kt_store #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_res_reg.status;
    assign m_slot   = m_res_reg.slot;
    assign m_fill   = m_res_reg.fill;

    // Checks on the sequencing.
    `KT_ASSERT_IMPLY(a_busy_excl, res_valid, !s_ready, "Result pending while accepting an item")
    `KT_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready, "Ready straight after an item")
    `KT_ASSERT_IMPLY(a_full_fill, m_valid && (m_status == ST_FULL), m_fill == FILL_W'(CAPACITY), "Full status with room left")
    `KT_ASSERT_IMPLY(a_slot_zero, m_valid && (m_status != ST_OK), m_slot == '0, "Slot set on a failed item")

endmodule

`default_nettype wire
